[rtl/single_precision_float_adder_macros.svh]
// Assertion macros used by the checker file.
`ifndef SINGLE_PRECISION_FLOAT_ADDER_MACROS_SVH
`define SINGLE_PRECISION_FLOAT_ADDER_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define SPFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/spfa_pkg.sv]
// Package with the item types and constants of the single-precision adder.
package spfa_pkg;

  localparam logic [7:0] EXP_INF = 8'd255;
  localparam logic [5:0] ALIGN_MAX = 6'd40;
  localparam logic [23:0] HIDDEN_ONE = 24'h800000;

  typedef struct packed {
    logic        sign_a;
    logic [7:0]  exponent_a;
    logic [22:0] fraction_a;
    logic        sign_b;
    logic [7:0]  exponent_b;
    logic [22:0] fraction_b;
  } in_item_t;

  typedef struct packed {
    logic        sum_sign;
    logic [7:0]  sum_exponent;
    logic [22:0] sum_fraction;
  } out_item_t;

endpackage

[rtl/single_precision_float_adder.sv]
// Pipelined IEEE 754 single-precision adder, top level.
//
// Usage: the input channel (in_valid, in_stall, in_data) carries one operand
// pair per item; the result channel (out_valid, out_stall, out_data) carries
// one sum per item, in order. An item is taken at an edge where valid is
// high and stall is low.
// The datapath has four register stages: alignment, add, normalize, round.
// out_valid is registered; an accepted item passes the alignment, add, normalize
// and round registers before its result can leave. Throughput is one item per
// cycle while out_stall is low, as every pipeline register then advances each clock.
// When the receiver stalls, the last stage holds its item while items behind
// it move on into empty stages, so in_stall rises only once the pipeline is full.
// Synchronous reset (rst_n low) empties all stages; no item is in flight
// afterwards.
// Operands with exponent 255 are treated as infinity, equal magnitudes of
// opposite sign give +0, overflow saturates and underflow flushes to zero.
module single_precision_float_adder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  spfa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output spfa_pkg::out_item_t out_data
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4 = !v4_r || !out_stall;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = !en1;

  // Stage 1: special cases, swap, negate and align.
  logic        spec1_nxt, spec1_r;
  logic        sps1_nxt, sps1_r;
  logic [7:0]  spe1_nxt, spe1_r;
  logic        sa1_nxt, sa1_r, sb1_nxt, sb1_r, sw1_nxt, sw1_r, df1_nxt, df1_r;
  logic [7:0]  ea1_nxt, ea1_r;
  logic [23:0] ma1_nxt, ma1_r, p1_nxt, p1_r;
  logic        g1_nxt, g1_r, r1_nxt, r1_r, st1_nxt, st1_r;

  logic        s_a, s_b;
  logic [7:0]  e_a, e_b, dexp;
  logic [22:0] f_a, f_b;
  logic [23:0] mb;
  logic [5:0]  dd;
  logic [63:0] ext;

  always_comb begin
    sps1_nxt = 1'b0;
    spe1_nxt = 8'd0;
    spec1_nxt = 1'b0;
    if (in_data.sign_a != in_data.sign_b && in_data.exponent_a == in_data.exponent_b
        && in_data.fraction_a == in_data.fraction_b) begin
      spec1_nxt = 1'b1;
    end else if (in_data.exponent_a == spfa_pkg::EXP_INF
                 || in_data.exponent_b == spfa_pkg::EXP_INF) begin
      spec1_nxt = 1'b1;
      spe1_nxt = spfa_pkg::EXP_INF;
    end
    sw1_nxt = in_data.exponent_a < in_data.exponent_b;
    if (sw1_nxt) begin
      s_a = in_data.sign_b; e_a = in_data.exponent_b; f_a = in_data.fraction_b;
      s_b = in_data.sign_a; e_b = in_data.exponent_a; f_b = in_data.fraction_a;
    end else begin
      s_a = in_data.sign_a; e_a = in_data.exponent_a; f_a = in_data.fraction_a;
      s_b = in_data.sign_b; e_b = in_data.exponent_b; f_b = in_data.fraction_b;
    end
    df1_nxt = s_a != s_b;
    ma1_nxt = {1'b1, f_a};
    mb = {1'b1, f_b};
    if (df1_nxt) begin
      mb = 24'd0 - mb;
    end
    dexp = e_a - e_b;
    dd = (dexp > 8'(spfa_pkg::ALIGN_MAX)) ? spfa_pkg::ALIGN_MAX : dexp[5:0];
    ext = {mb, 40'd0} >> dd;
    if (df1_nxt) begin
      ext = ext | ~(64'hFFFF_FFFF_FFFF_FFFF >> dd);
    end
    p1_nxt = ext[63:40];
    g1_nxt = ext[39];
    r1_nxt = ext[38];
    st1_nxt = |ext[37:0];
    sa1_nxt = s_a;
    sb1_nxt = s_b;
    ea1_nxt = e_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
    if (en1) begin
      spec1_r <= spec1_nxt; sps1_r <= sps1_nxt; spe1_r <= spe1_nxt;
      sa1_r <= sa1_nxt; sb1_r <= sb1_nxt; sw1_r <= sw1_nxt; df1_r <= df1_nxt;
      ea1_r <= ea1_nxt; ma1_r <= ma1_nxt; p1_r <= p1_nxt;
      g1_r <= g1_nxt; r1_r <= r1_nxt; st1_r <= st1_nxt;
    end
  end

  // Stage 2: add and fix sign.
  logic [24:0] sum2;
  logic [23:0] p2_nxt, p2_r;
  logic        c2_nxt, c2_r, sg2_nxt, sg2_r;
  logic        spec2_r, df2_r, g2_r, r2_r, st2_r;
  logic [7:0]  spe2_r, ea2_r;

  always_comb begin
    sum2 = {1'b0, ma1_r} + {1'b0, p1_r};
    c2_nxt = sum2[24];
    p2_nxt = sum2[23:0];
    sg2_nxt = sa1_r;
    if (df1_r && sum2[23] && !sum2[24]) begin
      p2_nxt = 24'd0 - sum2[23:0];
      if (!sw1_r) begin
        sg2_nxt = sb1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
    if (en2) begin
      p2_r <= p2_nxt; c2_r <= c2_nxt; sg2_r <= sg2_nxt;
      spec2_r <= spec1_r; spe2_r <= spe1_r | {7'd0, sps1_r};
      df2_r <= df1_r; g2_r <= g1_r; r2_r <= r1_r; st2_r <= st1_r; ea2_r <= ea1_r;
    end
  end

  // Stage 3: normalize.
  logic [24:0] v3;
  logic [4:0]  k3;
  logic [24:0] vs3;
  logic [23:0] p3_nxt, p3_r;
  logic        r3_nxt, r3_r, st3_nxt, st3_r, z3_nxt, z3_r;
  logic [9:0]  e3_nxt, e3_r;
  logic        spec3_r, sg3_r;
  logic [7:0]  spe3_r;

  always_comb begin
    v3 = {p2_r, g2_r};
    k3 = 5'd24;
    for (int i = 0; i < 25; i++) begin
      if (v3[i]) begin
        k3 = 5'(24 - i);
      end
    end
    vs3 = v3 << k3;
    z3_nxt = 1'b0;
    r3_nxt = r2_r;
    st3_nxt = st2_r;
    if (!df2_r && c2_r) begin
      st3_nxt = g2_r | r2_r | st2_r;
      r3_nxt = p2_r[0];
      p3_nxt = {1'b1, p2_r[23:1]};
      e3_nxt = {2'b00, ea2_r} + 10'd1;
    end else begin
      z3_nxt = v3 == 25'd0;
      if (k3 == 5'd0) begin
        st3_nxt = r2_r | st2_r;
        r3_nxt = g2_r;
      end else if (k3 >= 5'd2) begin
        r3_nxt = 1'b0;
        st3_nxt = 1'b0;
      end
      p3_nxt = vs3[24:1];
      e3_nxt = {2'b00, ea2_r} - {5'd0, k3};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
    if (en3) begin
      p3_r <= p3_nxt; r3_r <= r3_nxt; st3_r <= st3_nxt; z3_r <= z3_nxt;
      e3_r <= e3_nxt; spec3_r <= spec2_r; spe3_r <= spe2_r; sg3_r <= sg2_r;
    end
  end

  // Stage 4: round and pack.
  logic [24:0] pr4;
  logic [9:0]  e4;
  spfa_pkg::out_item_t o4_nxt, o4_r;

  always_comb begin
    pr4 = {1'b0, p3_r};
    e4 = e3_r;
    if (r3_r && (st3_r || p3_r[0])) begin
      pr4 = {1'b0, p3_r} + 25'd1;
      if (pr4[24]) begin
        pr4 = {1'b0, spfa_pkg::HIDDEN_ONE};
        e4 = e3_r + 10'd1;
      end
    end
    if (spec3_r) begin
      o4_nxt = '{1'b0, spe3_r, 23'd0};
    end else if (z3_r) begin
      o4_nxt = '{1'b0, 8'd0, 23'd0};
    end else if (!e4[9] && e4 >= 10'd255) begin
      o4_nxt = '{sg3_r, spfa_pkg::EXP_INF, 23'd0};
    end else if (e4[9] || e4 == 10'd0) begin
      o4_nxt = '{sg3_r, 8'd0, 23'd0};
    end else begin
      o4_nxt = '{sg3_r, e4[7:0], pr4[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
    if (en4) begin
      o4_r <= o4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data = o4_r;

endmodule

[rtl/spfa_checker.sv]
// Port-level checker for the single-precision adder, with its bind.
`include "single_precision_float_adder_macros.svh"
module spfa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input spfa_pkg::out_item_t out_data
);

  `SPFA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `SPFA_ASSERT_IMP(a_no_stall_empty, clk, rst_n, !out_valid, !in_stall)
  `SPFA_ASSERT_IMP(a_inf_frac, clk, rst_n, out_valid && out_data.sum_exponent == spfa_pkg::EXP_INF, out_data.sum_fraction == 23'd0)
  `SPFA_ASSERT_IMP(a_zero_frac, clk, rst_n, out_valid && out_data.sum_exponent == 8'd0, out_data.sum_fraction == 23'd0)

endmodule

bind single_precision_float_adder spfa_checker u_spfa_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
